### hdl/rraa_pkg.sv
package rraa_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CODE_W   = 5;
    localparam int INT_MV_W = 16;
    localparam int EXT_MV_W = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int USER_W     = 15;
    localparam int FACT_W     = 16;

    // shared multiplier operand and product widths
    localparam int MA_W = 19;
    localparam int MB_W = 17;
    localparam int PM_W = MA_W + MB_W;

    localparam logic [MA_W-1:0]     INT_SCALE     = 19'd316877;
    localparam logic [MA_W-1:0]     EXT_FRAC      = 19'd33887;
    localparam logic [EXT_MV_W-1:0] SINGLE_EXT_MV = 18'd5000;
    localparam logic [PM_W-1:0]     ROUND_Q16     = 36'd32768;
    localparam logic [PM_W-1:0]     ROUND_Q15     = 36'd16384;

    localparam logic [FACT_W-1:0] FACT_CORR_RST   = 16'd32768;
    localparam logic [CODE_W-1:0] FIRST_CODE_RST  = 5'd6;
    localparam logic [CODE_W-1:0] SECOND_CODE_RST = 5'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USER_INT    = 3'd0,
        CFG_FACT_INT    = 3'd1,
        CFG_USER_EXT    = 3'd2,
        CFG_FACT_EXT    = 3'd3,
        CFG_FIRST_CODE  = 3'd4,
        CFG_SECOND_CODE = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_INT_SCALE,
        ST_INT_CORR,
        ST_EXT_FRAC,
        ST_EXT_CORR,
        ST_WRITE
    } back_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                slot;
        logic                first;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [USER_W-1:0] user_int;
        logic [FACT_W-1:0] fact_int;
        logic [USER_W-1:0] user_ext;
        logic [FACT_W-1:0] fact_ext;
        logic [CODE_W-1:0] first_code;
        logic [CODE_W-1:0] second_code;
    } cfg_regs_t;

    function automatic logic [FACT_W-1:0] pick_corr(input logic [USER_W-1:0] user,
                                                    input logic [FACT_W-1:0] factory);
        logic [FACT_W-1:0] res;
        res = (user != '0) ? {user, 1'b0} : factory;
        return res;
    endfunction

endpackage

### hdl/rraa_front.sv
module rraa_front
    import rraa_pkg::*;
#(
    parameter int NUM_CHANNELS = 2,
    parameter int NUM_SAMPLES  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic                q_full,
    output logic                q_push,
    output item_t               q_item
);

    localparam int PASS_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(NUM_SAMPLES - 1);

    logic              slot_reg, slot_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              take;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign q_push  = take;

    assign q_item.sample = s_sample;
    assign q_item.slot   = slot_reg;
    assign q_item.first  = (pass_reg == '0);
    assign q_item.last   = (pass_reg == PASS_LAST);

    always_comb begin
        slot_next = slot_reg;
        pass_next = pass_reg;
        if (take) begin
            if (NUM_CHANNELS > 1 && !slot_reg) begin
                slot_next = 1'b1;
            end else begin
                slot_next = 1'b0;
                pass_next = (pass_reg == PASS_LAST) ? '0 : pass_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= 1'b0;
            pass_reg <= '0;
        end else begin
            slot_reg <= slot_next;
            pass_reg <= pass_next;
        end
    end

endmodule

### hdl/rraa_fifo.sv
module rraa_fifo
    import rraa_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn) !(pop && empty))
        else $error("queue read while empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != 2'd3) && ((wr_ptr_reg ^ rd_ptr_reg) == count_reg[0]))
        else $error("queue pointers and count disagree");
`endif

endmodule

### hdl/rraa_back.sv
module rraa_back
    import rraa_pkg::*;
#(
    parameter int NUM_CHANNELS = 2,
    parameter int NUM_SAMPLES  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_regs_t           cfg,
    input  logic                q_valid,
    input  item_t               q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_sampled_slot,
    output logic                m_average_updated,
    output logic [SAMPLE_W-1:0] m_average_value,
    output logic [CODE_W-1:0]   m_next_select,
    output logic [INT_MV_W-1:0] m_internal_mv,
    output logic [EXT_MV_W-1:0] m_external_mv
);

    localparam int LOG_N     = $clog2(NUM_SAMPLES);
    localparam int SUM_W     = SAMPLE_W + LOG_N;
    localparam int DIV_SHIFT = SUM_W + LOG_N;
    localparam int DIV_MUL   = (2 ** DIV_SHIFT) / NUM_SAMPLES + 1;
    localparam int MUL_W     = SUM_W + 2;
    localparam int PROD_W    = SUM_W + MUL_W;

    back_state_t state_reg, state_next;

    logic [SUM_W-1:0]    sum_reg [2];
    logic [SAMPLE_W-1:0] avg_reg [2];
    logic                slot_reg;
    logic                last_reg;
    logic [PM_W-1:0]     prod_reg;
    logic [INT_MV_W-1:0] int_mv_reg;

    logic                m_valid_reg;
    logic                m_slot_reg;
    logic                m_updated_reg;
    logic [SAMPLE_W-1:0] m_avg_reg;
    logic [CODE_W-1:0]   m_select_reg;
    logic [INT_MV_W-1:0] m_int_reg;
    logic [EXT_MV_W-1:0] m_ext_reg;

    logic                out_free;
    logic                avg_load;
    logic                int_load;
    logic                out_load;
    logic [MA_W-1:0]     mul_a;
    logic [MB_W-1:0]     mul_b;
    logic [PROD_W-1:0]   div_prod;
    logic [PM_W-1:0]     rnd16;
    logic [PM_W-1:0]     rnd15;
    logic [15:0]         t_int;
    logic [16:0]         t_ext;
    logic [16:0]         whole_ext;
    logic [FACT_W-1:0]   corr_int;
    logic [FACT_W-1:0]   corr_ext;
    logic [CODE_W-1:0]   select_next;
    logic [EXT_MV_W-1:0] ext_next;

    assign out_free = !m_valid_reg || m_ready;

    assign div_prod  = PROD_W'(sum_reg[slot_reg]) * PROD_W'(DIV_MUL);
    assign rnd16     = prod_reg + ROUND_Q16;
    assign rnd15     = prod_reg + ROUND_Q15;
    assign t_int     = rnd16[31:16];
    assign whole_ext = {1'b0, avg_reg[1], 4'b0} + {4'b0, avg_reg[1], 1'b0};
    assign t_ext     = whole_ext + 17'(rnd16[27:16]);
    assign corr_int  = pick_corr(cfg.user_int, cfg.fact_int);
    assign corr_ext  = pick_corr(cfg.user_ext, cfg.fact_ext);

    assign select_next = (NUM_CHANNELS > 1 && !slot_reg) ? cfg.second_code : cfg.first_code;
    assign ext_next    = (NUM_CHANNELS > 1) ? rnd15[32:15] : SINGLE_EXT_MV;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (q_valid) state_next = ST_AVG;
            ST_AVG:       state_next = ST_INT_SCALE;
            ST_INT_SCALE: state_next = ST_INT_CORR;
            ST_INT_CORR:  state_next = ST_EXT_FRAC;
            ST_EXT_FRAC:  state_next = ST_EXT_CORR;
            ST_EXT_CORR:  state_next = ST_WRITE;
            ST_WRITE:     if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        avg_load = 1'b0;
        int_load = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
            end
            ST_AVG: begin
                avg_load = last_reg;
            end
            ST_INT_SCALE: begin
                mul_a = INT_SCALE;
                mul_b = MB_W'(avg_reg[0]);
            end
            ST_INT_CORR: begin
                mul_a = MA_W'(t_int);
                mul_b = MB_W'(corr_int);
            end
            ST_EXT_FRAC: begin
                int_load = 1'b1;
                mul_a    = EXT_FRAC;
                mul_b    = MB_W'(avg_reg[1]);
            end
            ST_EXT_CORR: begin
                mul_a = MA_W'(t_ext);
                mul_b = MB_W'(corr_ext);
            end
            ST_WRITE: begin
                out_load = out_free;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg != ST_WRITE) begin
            prod_reg <= PM_W'(mul_a) * PM_W'(mul_b);
        end
        if (q_pop) begin
            slot_reg <= q_item.slot;
            last_reg <= q_item.last;
            sum_reg[q_item.slot] <= q_item.first ? SUM_W'(q_item.sample)
                                                 : sum_reg[q_item.slot] + SUM_W'(q_item.sample);
        end
        if (int_load) begin
            int_mv_reg <= rnd15[30:15];
        end
        if (out_load) begin
            m_slot_reg    <= slot_reg;
            m_updated_reg <= last_reg;
            m_avg_reg     <= avg_reg[slot_reg];
            m_select_reg  <= select_next;
            m_int_reg     <= int_mv_reg;
            m_ext_reg     <= ext_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            avg_reg[0]  <= '0;
            avg_reg[1]  <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (avg_load) begin
                avg_reg[slot_reg] <= div_prod[DIV_SHIFT +: SAMPLE_W];
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_sampled_slot    = m_slot_reg;
    assign m_average_updated = m_updated_reg;
    assign m_average_value   = m_avg_reg;
    assign m_next_select     = m_select_reg;
    assign m_internal_mv     = m_int_reg;
    assign m_external_mv     = m_ext_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result word raised outside the write step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && !out_free) |=> (state_reg == ST_WRITE))
        else $error("write step left while result register busy");
`endif

endmodule

### hdl/round_robin_adc_averager.sv
// path: an accepted sample word goes through the two-entry queue and the back end
// sequence; the result word is raised once the result register is free
// the back end takes the next word from the queue only after its sequence of average
// update and four passes through the single shared multiplier returns to idle
// reset: synchronous active low aresetn; slot, pass count, averages and queue clear,
// registers return to their documented values
module round_robin_adc_averager
    import rraa_pkg::*;
#(
    parameter int NUM_CHANNELS = 2,
    parameter int NUM_SAMPLES  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_sampled_slot,
    output logic                  m_average_updated,
    output logic [SAMPLE_W-1:0]   m_average_value,
    output logic [CODE_W-1:0]     m_next_select,
    output logic [INT_MV_W-1:0]   m_internal_mv,
    output logic [EXT_MV_W-1:0]   m_external_mv
);

    cfg_regs_t cfg_reg;
    item_t     push_item;
    item_t     pop_item;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.user_int    <= '0;
            cfg_reg.fact_int    <= FACT_CORR_RST;
            cfg_reg.user_ext    <= '0;
            cfg_reg.fact_ext    <= FACT_CORR_RST;
            cfg_reg.first_code  <= FIRST_CODE_RST;
            cfg_reg.second_code <= SECOND_CODE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_USER_INT:    cfg_reg.user_int    <= cfg_data[USER_W-1:0];
                CFG_FACT_INT:    cfg_reg.fact_int    <= cfg_data[FACT_W-1:0];
                CFG_USER_EXT:    cfg_reg.user_ext    <= cfg_data[USER_W-1:0];
                CFG_FACT_EXT:    cfg_reg.fact_ext    <= cfg_data[FACT_W-1:0];
                CFG_FIRST_CODE:  cfg_reg.first_code  <= cfg_data[CODE_W-1:0];
                CFG_SECOND_CODE: cfg_reg.second_code <= cfg_data[CODE_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    rraa_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_SAMPLES  (NUM_SAMPLES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .q_full   (full),
        .q_push   (push),
        .q_item   (push_item)
    );

    rraa_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    rraa_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_SAMPLES  (NUM_SAMPLES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .q_valid           (!empty),
        .q_item            (pop_item),
        .q_pop             (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sampled_slot    (m_sampled_slot),
        .m_average_updated (m_average_updated),
        .m_average_value   (m_average_value),
        .m_next_select     (m_next_select),
        .m_internal_mv     (m_internal_mv),
        .m_external_mv     (m_external_mv)
    );

endmodule

### test/adc_average_checker.sv
`timescale 1ns / 1ps

module adc_average_checker
    import rraa_pkg::*;
#(
    parameter int NUM_CHANNELS = 2,
    parameter int NUM_SAMPLES  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_sampled_slot,
    input  logic                  m_average_updated,
    input  logic [SAMPLE_W-1:0]   m_average_value,
    input  logic [CODE_W-1:0]     m_next_select,
    input  logic [INT_MV_W-1:0]   m_internal_mv,
    input  logic [EXT_MV_W-1:0]   m_external_mv,
    output int                    mismatches,
    output int                    pending,
    output int                    words_checked,
    output int                    averages_done
);

    localparam longint unsigned EXT_WHOLE = 18;

    typedef struct {
        logic                slot;
        logic                updated;
        logic [SAMPLE_W-1:0] average;
        logic [CODE_W-1:0]   select;
        logic [INT_MV_W-1:0] int_mv;
        logic [EXT_MV_W-1:0] ext_mv;
    } reading_t;

    reading_t readings_due[$];
    reading_t oldest;
    cfg_regs_t regs;

    logic                cur_slot;
    int unsigned         pass_idx;
    int unsigned         slot_sums [2];
    logic [SAMPLE_W-1:0] slot_avgs [2];
    int                  fail_total;
    int                  checked_total;
    int                  updates_total;

    function automatic longint unsigned corr_factor(input logic [USER_W-1:0] user,
                                                    input logic [FACT_W-1:0] factory);
        return (user != '0) ? 64'(user) * 2 : 64'(factory);
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    task automatic predict_reading(input logic [SAMPLE_W-1:0] smp);
        reading_t          r;
        int unsigned       slot;
        longint unsigned   a;
        longint unsigned   t;
        longint unsigned   mv;
        slot = (NUM_CHANNELS > 1) ? int'(cur_slot) : 0;
        r.slot = slot[0];
        r.updated = 1'b0;
        if (pass_idx == 0)
            slot_sums[slot] = 32'(smp);
        else
            slot_sums[slot] += 32'(smp);
        if (pass_idx == NUM_SAMPLES - 1) begin
            slot_avgs[slot] = SAMPLE_W'(slot_sums[slot] / NUM_SAMPLES);
            r.updated = 1'b1;
        end
        if (NUM_CHANNELS > 1 && slot == 0) begin
            cur_slot = 1'b1;
        end else begin
            cur_slot = 1'b0;
            pass_idx = (pass_idx + 1 >= NUM_SAMPLES) ? 0 : pass_idx + 1;
        end

        // internal battery from slot zero
        a = 64'(slot_avgs[0]);
        t = (a * INT_SCALE + ROUND_Q16) >> 16;
        mv = (t * corr_factor(regs.user_int, regs.fact_int) + ROUND_Q15) >> 15;
        r.int_mv = mv[INT_MV_W-1:0];

        // external battery from slot one
        if (NUM_CHANNELS > 1) begin
            a = 64'(slot_avgs[1]);
            t = a * EXT_WHOLE + ((a * EXT_FRAC + ROUND_Q16) >> 16);
            mv = (t * corr_factor(regs.user_ext, regs.fact_ext) + ROUND_Q15) >> 15;
            r.ext_mv = mv[EXT_MV_W-1:0];
        end else begin
            r.ext_mv = SINGLE_EXT_MV;
        end

        r.average = slot_avgs[slot];
        r.select = (NUM_CHANNELS > 1 && cur_slot) ? regs.second_code : regs.first_code;
        if (r.updated)
            updates_total++;
        readings_due.push_back(r);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.user_int    = '0;
            regs.fact_int    = FACT_CORR_RST;
            regs.user_ext    = '0;
            regs.fact_ext    = FACT_CORR_RST;
            regs.first_code  = FIRST_CODE_RST;
            regs.second_code = SECOND_CODE_RST;
            cur_slot = 1'b0;
            pass_idx = 0;
            slot_sums[0] = 0;
            slot_sums[1] = 0;
            slot_avgs[0] = '0;
            slot_avgs[1] = '0;
            readings_due.delete();
            fail_total = 0;
            checked_total = 0;
            updates_total = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    $error("result word with no sample word pending");
                    fail_total++;
                end else begin
                    oldest = readings_due.pop_front();
                    compare_field("sampled_slot", oldest.slot, m_sampled_slot);
                    compare_field("average_updated", oldest.updated, m_average_updated);
                    compare_field("average_value", oldest.average, m_average_value);
                    compare_field("next_select", oldest.select, m_next_select);
                    compare_field("internal_mv", oldest.int_mv, m_internal_mv);
                    compare_field("external_mv", oldest.ext_mv, m_external_mv);
                    checked_total++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_USER_INT:    regs.user_int    = cfg_data[USER_W-1:0];
                    CFG_FACT_INT:    regs.fact_int    = cfg_data[FACT_W-1:0];
                    CFG_USER_EXT:    regs.user_ext    = cfg_data[USER_W-1:0];
                    CFG_FACT_EXT:    regs.fact_ext    = cfg_data[FACT_W-1:0];
                    CFG_FIRST_CODE:  regs.first_code  = cfg_data[CODE_W-1:0];
                    CFG_SECOND_CODE: regs.second_code = cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_reading(s_sample);
        end
        mismatches    <= fail_total;
        pending       <= readings_due.size();
        words_checked <= checked_total;
        averages_done <= updates_total;
    end

endmodule

### test/round_robin_adc_averager_test.sv
`timescale 1ns / 1ps

module round_robin_adc_averager_test;
    import rraa_pkg::*;

    localparam int NUM_CHANNELS    = 2;
    localparam int NUM_SAMPLES     = 16;
    localparam int FRAME_LEN       = NUM_CHANNELS * NUM_SAMPLES;
    localparam int NUM_PHASES      = 6;
    localparam int WORDS_PER_PHASE = 175;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int NUM_DIRECTED    = 24;

    typedef enum {FILL_RANDOM, FILL_FULL, FILL_ZERO, FILL_NEAR_TOP, FILL_SPLIT} fill_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample  = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_sampled_slot;
    logic                  m_average_updated;
    logic [SAMPLE_W-1:0]   m_average_value;
    logic [CODE_W-1:0]     m_next_select;
    logic [INT_MV_W-1:0]   m_internal_mv;
    logic [EXT_MV_W-1:0]   m_external_mv;

    int mismatches;
    int readings_pending;
    int words_checked;
    int averages_done;
    int words_sent  = 0;
    int cfg_writes  = 0;
    int quiet_cycles = 0;
    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    bit hold_req = 1'b0;

    logic [SAMPLE_W-1:0] directed_words [NUM_DIRECTED] = '{
        12'h000, 12'hFFF, 12'h001, 12'hFFE, 12'h800, 12'h7FF, 12'h555, 12'hAAA,
        12'hFFF, 12'h000, 12'h0F0, 12'hF0F, 12'h123, 12'hEDC, 12'h400, 12'hBFF,
        12'h002, 12'hFFD, 12'h3FF, 12'hC00, 12'h100, 12'hEFF, 12'h010, 12'hFEF
    };

    round_robin_adc_averager #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .NUM_SAMPLES (NUM_SAMPLES)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sampled_slot   (m_sampled_slot),
        .m_average_updated(m_average_updated),
        .m_average_value  (m_average_value),
        .m_next_select    (m_next_select),
        .m_internal_mv    (m_internal_mv),
        .m_external_mv    (m_external_mv)
    );

    adc_average_checker #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .NUM_SAMPLES (NUM_SAMPLES)
    ) checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sampled_slot   (m_sampled_slot),
        .m_average_updated(m_average_updated),
        .m_average_value  (m_average_value),
        .m_next_select    (m_next_select),
        .m_internal_mv    (m_internal_mv),
        .m_external_mv    (m_external_mv),
        .mismatches       (mismatches),
        .pending          (readings_pending),
        .words_checked    (words_checked),
        .averages_done    (averages_done)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = pick_gap(tx_idle);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
    endtask

    task automatic program_regs(input int ph);
        logic [CFG_DATA_W-1:0] vals [6];
        case (ph)
            1: vals = '{16'h7FFF, 16'h0001, 16'h7FFF, 16'h0001, 16'd18, 16'd0};
            2: vals = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd31, 16'd19};
            3: vals = '{16'h8000, 16'h0000, 16'h0001, 16'h0000, 16'd0, 16'd18};
            default: begin
                foreach (vals[i])
                    vals[i] = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                // user values of zero fall back to the factory factor
                if ($urandom_range(0, 1))
                    vals[CFG_USER_INT] = '0;
                if ($urandom_range(0, 1))
                    vals[CFG_USER_EXT] = '0;
                write_reg(CFG_IDX_W'($urandom_range(CFG_SECOND_CODE + 1, 2**CFG_IDX_W - 1)),
                          CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            end
        endcase
        for (int i = CFG_USER_INT; i <= CFG_SECOND_CODE; i++)
            write_reg(CFG_IDX_W'(i), vals[i]);
        cfg_valid <= 1'b0;
    endtask

    // result side
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                stall = pick_gap(rx_idle);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        fill_mode_t mode;
        int         r;
        mode = FILL_RANDOM;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0)
                program_regs(ph);
            tx_idle = (ph != 2 && ph != 4);
            rx_idle = (ph != 2 && ph != 3);
            if (ph == 2)
                hold_req = 1'b1;

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (ph == 0 && n < NUM_DIRECTED) begin
                    send_word(directed_words[n]);
                end else begin
                    // content changes only on whole round robin frames
                    if (words_sent % FRAME_LEN == 0) begin
                        r = $urandom_range(0, 99);
                        if (r < 45)
                            mode = FILL_RANDOM;
                        else if (r < 60)
                            mode = FILL_FULL;
                        else if (r < 70)
                            mode = FILL_ZERO;
                        else if (r < 85)
                            mode = FILL_NEAR_TOP;
                        else
                            mode = FILL_SPLIT;
                    end
                    case (mode)
                        FILL_FULL:     send_word('1);
                        FILL_ZERO:     send_word('0);
                        FILL_NEAR_TOP: send_word(SAMPLE_W'(12'hFFF - $urandom_range(0, 15)));
                        FILL_SPLIT: begin
                            if (words_sent % NUM_CHANNELS == 0)
                                send_word('1);
                            else
                                send_word(SAMPLE_W'($urandom_range(0, 15)));
                        end
                        default:       send_word(SAMPLE_W'($urandom_range(0, 4095)));
                    endcase
                end
            end

            s_valid <= 1'b0;
            do @(posedge aclk); while (readings_pending != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d sample words over %0d register settings, with idle, %s",
                 words_checked, NUM_PHASES, "back-to-back and long-stall traffic");
        $display("%0d averages completed, %0d register writes including an unused index",
                 averages_done, cfg_writes);
        if (mismatches == 0 && readings_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
